// ===== rtl/tlpq_pkg.sv =====
// Shared types and constants for the three-level priority queue.
// No dependencies; tlpq_ctrl, tlpq_dp and the top level refer to this package.
`default_nettype none

package tlpq_pkg;

  // Sizing of the entry pool and the levels
  localparam int QUEUE_DEPTH = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int LEVEL_COUNT = 3;

  // Widths that follow from the sizing
  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  // Fixed field widths of the words
  localparam int PRIO_W = 2;
  localparam int DATA_W = 32;

  // Opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PRIO_W-1:0] LEVEL_MAX = PRIO_W'(LEVEL_COUNT);

  // Input word
  typedef struct packed {
    logic              opcode;
    logic [PRIO_W-1:0] priority_req;
    logic [DATA_W-1:0] data_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [DATA_W-1:0] out_data;
    logic              out_valid;
    logic              accepted;
    logic              empty_res;
    logic              full_res;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch input word, issue memory reads
    logic commit;  // update pointers, write memories, load result
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlpq_ctrl.sv =====
// Controller of the priority queue: accept/execute sequencing and result handshake.
// Depends on tlpq_pkg.
`default_nettype none

module tlpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tlpq_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic oval_r, oval_nxt;

  // Commands
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.load   = in_valid && in_ready;
    cmd.commit = (state_r == ST_EXEC) && (!oval_r || out_ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result slot: filled on commit, emptied when taken
  always_comb begin
    oval_nxt = oval_r;
    if (cmd.commit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

endmodule

`default_nettype wire

// ===== rtl/tlpq_dp.sv =====
// Datapath of the priority queue: level pointers, free chain, entry memories, result.
// Depends on tlpq_pkg and tlpq_ram.
`default_nettype none

module tlpq_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tlpq_pkg::cmd_t      cmd,
  input  wire tlpq_pkg::in_word_t  in_word,
  output tlpq_pkg::out_word_t      out_word
);

  localparam int IDX_W  = tlpq_pkg::IDX_W;
  localparam int CNT_W  = tlpq_pkg::CNT_W;
  localparam int LIW    = tlpq_pkg::LVL_IDX_W;
  localparam int LEVELS = tlpq_pkg::LEVEL_COUNT;
  localparam int WW     = tlpq_pkg::WORD_WIDTH;
  localparam int DW     = tlpq_pkg::DATA_W;
  localparam int PW     = tlpq_pkg::PRIO_W;

  // Pointer state
  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] head_nxt [LEVELS];
  logic [IDX_W-1:0] tail_r [LEVELS];
  logic [IDX_W-1:0] tail_nxt [LEVELS];
  logic [CNT_W-1:0] count_r [LEVELS];
  logic [CNT_W-1:0] count_nxt [LEVELS];
  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0] hw_r, hw_nxt;      // entries handed out fresh since reset
  logic [CNT_W-1:0] used_r, used_nxt;

  // Latched operation
  logic             is_deq_r;
  logic             go_r;
  logic             fresh_r;
  logic [LIW-1:0]   lvl_r;
  logic [IDX_W-1:0] idx_r;
  logic [WW-1:0]    data_r;

  tlpq_pkg::out_word_t res_r, res_nxt;

  // Load-side decode
  logic             ld_deq;
  logic             deq_any;
  logic [LIW-1:0]   deq_lvl;
  logic [LIW-1:0]   enq_lvl;
  logic             enq_lvl_ok;
  logic             fresh;
  logic             ld_go;
  logic [LIW-1:0]   ld_lvl;
  logic [IDX_W-1:0] ld_idx;
  logic [IDX_W-1:0] link_raddr;

  // Memory ports
  logic             word_we;
  logic [WW-1:0]    word_rdata;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;
  logic [IDX_W-1:0] link_rdata;

  // Most urgent nonempty level, and enqueue decode
  always_comb begin
    deq_any = 1'b0;
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0) begin
        deq_any = 1'b1;
        deq_lvl = LIW'(i);
      end
    end
    ld_deq     = (in_word.opcode == tlpq_pkg::OP_DEQ);
    enq_lvl    = LIW'(in_word.priority_req - PW'(1));
    enq_lvl_ok = (in_word.priority_req != '0) &&
                 (in_word.priority_req <= tlpq_pkg::LEVEL_MAX);
    fresh      = (hw_r != tlpq_pkg::DEPTH_CNT);
    ld_go      = ld_deq ? deq_any : (enq_lvl_ok && (used_r != tlpq_pkg::DEPTH_CNT));
    ld_lvl     = ld_deq ? deq_lvl : enq_lvl;
    ld_idx     = ld_deq ? head_r[deq_lvl] : (fresh ? hw_r[IDX_W-1:0] : free_head_r);
    link_raddr = ld_deq ? head_r[deq_lvl] : free_head_r;
  end

  // Latch the operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_deq_r <= ld_deq;
      go_r     <= ld_go;
      fresh_r  <= fresh;
      lvl_r    <= ld_lvl;
      idx_r    <= ld_idx;
      data_r   <= WW'(in_word.data_value);
    end
  end

  // Entry memories
  tlpq_ram #(.WIDTH(WW), .DEPTH(tlpq_pkg::QUEUE_DEPTH)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (idx_r),
    .wdata (data_r),
    .re    (cmd.load),
    .raddr (head_r[deq_lvl]),
    .rdata (word_rdata)
  );

  tlpq_ram #(.WIDTH(IDX_W), .DEPTH(tlpq_pkg::QUEUE_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.load),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // Memory writes on commit
  always_comb begin
    word_we    = cmd.commit && go_r && !is_deq_r;
    link_we    = cmd.commit && go_r && (is_deq_r || (count_r[lvl_r] != '0));
    link_waddr = is_deq_r ? idx_r : tail_r[lvl_r];
    link_wdata = is_deq_r ? free_head_r : idx_r;
  end

  // Pointer update and result
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    used_nxt      = used_r;
    res_nxt.out_data  = '0;
    res_nxt.out_valid = 1'b0;
    res_nxt.accepted  = 1'b0;
    if (go_r && is_deq_r) begin
      // unlink head of the level, return entry to free chain
      res_nxt.out_data  = DW'(word_rdata);
      res_nxt.out_valid = 1'b1;
      count_nxt[lvl_r]  = count_r[lvl_r] - CNT_W'(1);
      used_nxt          = used_r - CNT_W'(1);
      if (count_r[lvl_r] != CNT_W'(1)) begin
        head_nxt[lvl_r] = link_rdata;
      end else begin
        head_nxt[lvl_r] = '0;
        tail_nxt[lvl_r] = '0;
      end
      free_head_nxt = idx_r;
    end else if (go_r) begin
      // append entry to the tail of the level
      res_nxt.accepted = 1'b1;
      if (count_r[lvl_r] == '0) begin
        head_nxt[lvl_r] = idx_r;
      end
      tail_nxt[lvl_r]  = idx_r;
      count_nxt[lvl_r] = count_r[lvl_r] + CNT_W'(1);
      used_nxt         = used_r + CNT_W'(1);
      if (fresh_r) begin
        hw_nxt = hw_r + CNT_W'(1);
      end else begin
        free_head_nxt = link_rdata;
      end
    end
    res_nxt.empty_res = (used_nxt == '0);
    res_nxt.full_res  = (used_nxt == tlpq_pkg::DEPTH_CNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
      free_head_r <= '0;
      hw_r        <= '0;
      used_r      <= '0;
    end else if (cmd.commit) begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      used_r      <= used_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign out_word = res_r;

endmodule

`default_nettype wire

// ===== rtl/three_level_priority_queue.sv =====
// Top level of the three-level strict-priority queue.
// Depends on tlpq_pkg, tlpq_ctrl, tlpq_dp (and tlpq_ram through tlpq_dp).
//
//   Channel  | Handshake            | Word
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | in_word  : opcode, priority_req, data_value
//   result   | out_valid / out_ready| out_word : out_data, out_valid, accepted,
//            |                      |            empty_res, full_res
//
// Each word passes a load step that reads the entry and link memories, then an execute
// step that writes the memories, the level pointers and the result register.
// One result word per input word. Synchronous active-low reset empties every level;
// entries are handed out in index order until all have been used once, then
// from the free chain, so no clearing pass is needed. A result left waiting holds
// the next word in its execute cycle until out_ready.
`default_nettype none

module three_level_priority_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlpq_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlpq_pkg::out_word_t      out_word
);

  tlpq_pkg::cmd_t cmd;

  tlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tlpq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
